// File: hdl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants for the torque command shaper
// Word layouts, configuration register indexes and DShot code constants.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int TorqueW = 16;
  localparam int RpmW    = 20;
  localparam int GainW   = 16;
  localparam int DshotW  = 11;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 20;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SMOOTHING_ALPHA = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_RPM     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DECAY_FACTOR    = 2'd2;

  localparam logic [GainW-1:0] ALPHA_RESET   = 16'd6554;
  localparam logic [RpmW-1:0]  RELEASE_RESET = 20'd300;
  localparam logic [GainW-1:0] DECAY_RESET   = 16'd65208;

  // sign codes kept in the lockout state
  localparam logic [1:0] SIGN_NONE = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // DShot mapping
  localparam logic [16:0]       DSHOT_DEADBAND = 17'd40;
  localparam logic [12:0]       FULL_SCALE     = 13'd4096;
  localparam logic [9:0]        DSHOT_SPAN     = 10'd999;
  localparam logic [DshotW-1:0] DSHOT_STOP     = 11'd0;
  localparam logic [DshotW-1:0] DSHOT_REV_BASE = 11'd48;
  localparam logic [DshotW-1:0] DSHOT_FWD_BASE = 11'd1048;

  localparam logic ACT_TORQUE = 1'b0;
  localparam logic ACT_DECAY  = 1'b1;

  typedef struct packed {
    logic [GainW-1:0] smoothing_alpha;
    logic [RpmW-1:0]  release_rpm;
    logic [GainW-1:0] decay_factor;
  } tcs_cfg_t;

  typedef struct packed {
    logic                      action;
    logic signed [TorqueW-1:0] torque;
    logic [RpmW-1:0]           measured_rpm;
  } tcs_cmd_t;

  typedef struct packed {
    logic signed [TorqueW-1:0] applied_torque;
    logic                      reversal_blocked;
  } tcs_mid_t;

  typedef struct packed {
    logic [DshotW-1:0]         dshot_value;
    logic signed [TorqueW-1:0] applied_torque;
    logic                      reversal_blocked;
  } tcs_res_t;

endpackage

// File: hdl/tcs_if.sv
// ----------------------------------------------------------------------------
// tcs_if: valid/ready channels of the torque command shaper
// One interface for command words and one for result words.
// ----------------------------------------------------------------------------
interface tcs_cmd_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [tcs_pkg::TorqueW-1:0] torque;
  logic [tcs_pkg::RpmW-1:0]           measured_rpm;

  modport source (output valid, output action, output torque, output measured_rpm,
                  input ready);
  modport sink   (input valid, input action, input torque, input measured_rpm,
                  output ready);
endinterface

interface tcs_res_if;
  logic                               valid;
  logic                               ready;
  logic [tcs_pkg::DshotW-1:0]         dshot_value;
  logic signed [tcs_pkg::TorqueW-1:0] applied_torque;
  logic                               reversal_blocked;

  modport source (output valid, output dshot_value, output applied_torque,
                  output reversal_blocked, input ready);
  modport sink   (input valid, input dshot_value, input applied_torque,
                  input reversal_blocked, output ready);
endinterface

// File: hdl/torque_command_shaper.sv
// ----------------------------------------------------------------------------
// torque_command_shaper: reversal lockout, smoothing and DShot mapping
// Shapes torque commands and slow-down ticks into applied torque and codes.
// ----------------------------------------------------------------------------
//   channel  dir  fields
//   cmd      in   action, torque, measured_rpm
//   res      out  dshot_value, applied_torque, reversal_blocked
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One word per cycle sustained while res.ready holds; a result passes the input
// register, core/state register and DShot result register in that order.
// The shared Q0.16 scaler in the core sets the cycle time.
// Reset clears state and loads register defaults.
// Each stage holds its word while the next is full; ready ripples back.
module torque_command_shaper (
  input  logic                           clk,
  input  logic                           rst,
  tcs_cmd_if.sink                        cmd,
  tcs_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [tcs_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tcs_pkg::CfgDataW-1:0]   cfg_data
);

  tcs_pkg::tcs_cfg_t cfg;
  tcs_pkg::tcs_cmd_t cmd_word;
  tcs_pkg::tcs_mid_t mid_word;
  tcs_pkg::tcs_res_t res_word;
  logic              mid_valid;
  logic              mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_alpha <= tcs_pkg::ALPHA_RESET;
      cfg.release_rpm     <= tcs_pkg::RELEASE_RESET;
      cfg.decay_factor    <= tcs_pkg::DECAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcs_pkg::REG_SMOOTHING_ALPHA: cfg.smoothing_alpha <= cfg_data[15:0];
        tcs_pkg::REG_RELEASE_RPM:     cfg.release_rpm     <= cfg_data;
        tcs_pkg::REG_DECAY_FACTOR:    cfg.decay_factor    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cmd_word.action       = cmd.action;
  assign cmd_word.torque       = cmd.torque;
  assign cmd_word.measured_rpm = cmd.measured_rpm;

  tcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_word   (cmd_word),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_word  (mid_word)
  );

  tcs_dshot u_dshot (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_word  (mid_word),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_word  (res_word)
  );

  assign res.dshot_value      = res_word.dshot_value;
  assign res.applied_torque   = res_word.applied_torque;
  assign res.reversal_blocked = res_word.reversal_blocked;

  // codes between stop and the reverse base never appear
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.dshot_value == tcs_pkg::DSHOT_STOP ||
                   res.dshot_value >= tcs_pkg::DSHOT_REV_BASE))
    else $error("dshot code in reserved range");

  // forward codes only for positive torque, reverse only for negative
  a_code_sign: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.dshot_value != tcs_pkg::DSHOT_STOP) |->
      ((res.dshot_value >= tcs_pkg::DSHOT_FWD_BASE) == !res.applied_torque[15]))
    else $error("dshot direction disagrees with applied torque");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

endmodule

// File: hdl/tcs_core.sv
// ----------------------------------------------------------------------------
// tcs_core: input register, reversal lockout, smoothing and decay
// Holds the shaper state; one shared Q0.16 scaler serves smoothing and decay.
// ----------------------------------------------------------------------------
module tcs_core (
  input  logic              clk,
  input  logic              rst,
  input  tcs_pkg::tcs_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcs_pkg::tcs_cmd_t in_word,
  output logic              mid_valid,
  input  logic              mid_ready,
  output tcs_pkg::tcs_mid_t mid_word
);

  // round(a * g / 65536), nearest, ties away from zero
  function automatic logic signed [17:0] scale_q16(input logic signed [16:0] a,
                                                   input logic [15:0] g);
    logic signed [33:0] p;
    logic [33:0]        pa;
    logic [33:0]        pr;
    logic signed [17:0] q;
    p  = 34'(a) * 34'($signed({1'b0, g}));
    pa = p[33] ? 34'(-p) : 34'(p);
    pr = pa + 34'd32768;
    q  = $signed({1'b0, pr[32:16]});
    return p[33] ? -q : q;
  endfunction

  logic              s1_valid;
  tcs_pkg::tcs_cmd_t s1;
  logic              s2_ready;
  logic              step;

  logic signed [15:0] applied_level;
  logic signed [15:0] smoothed_level;
  logic               waiting_flag;
  logic [1:0]         last_sign;

  logic signed [15:0] applied_next;
  logic signed [15:0] smoothed_next;
  logic               waiting_next;
  logic [1:0]         last_sign_next;

  logic signed [15:0] t;
  logic [1:0]         s;
  logic               s_nz;
  logic               low_rpm;
  logic               wait_now;
  logic signed [15:0] target;
  logic [16:0]        abs_target;
  logic [16:0]        abs_smoothed;
  logic signed [16:0] diff;
  logic signed [16:0] mul_a;
  logic [15:0]        mul_g;
  logic signed [17:0] scaled;
  logic signed [17:0] sum;

  assign s2_ready = !mid_valid || mid_ready;
  assign in_ready = !s1_valid || s2_ready;
  assign step     = s1_valid && s2_ready;

  always_comb begin
    t       = s1.torque;
    s_nz    = (t != 16'sd0);
    s       = !s_nz ? tcs_pkg::SIGN_NONE : (t[15] ? tcs_pkg::SIGN_NEG : tcs_pkg::SIGN_POS);
    low_rpm = (s1.measured_rpm < cfg.release_rpm);
    wait_now = waiting_flag ||
               (s_nz && last_sign != tcs_pkg::SIGN_NONE && s != last_sign);

    target         = t;
    waiting_next   = 1'b0;
    last_sign_next = last_sign;
    if (wait_now) begin
      if (s_nz && s == last_sign) begin
        waiting_next = 1'b0;
      end else if (low_rpm) begin
        waiting_next = 1'b0;
        if (s_nz) last_sign_next = s;
      end else begin
        target       = 16'sd0;
        waiting_next = 1'b1;
      end
    end else begin
      if (s_nz) last_sign_next = s;
    end

    abs_target   = target[15] ? 17'(-{target[15], target}) : {1'b0, target};
    abs_smoothed = smoothed_level[15] ? 17'(-{smoothed_level[15], smoothed_level})
                                      : {1'b0, smoothed_level};
    diff = {target[15], target} - {smoothed_level[15], smoothed_level};

    // one multiplier: decay tick scales applied level, command scales the error
    if (s1.action == tcs_pkg::ACT_DECAY) begin
      mul_a = {applied_level[15], applied_level};
      mul_g = cfg.decay_factor;
    end else begin
      mul_a = diff;
      mul_g = cfg.smoothing_alpha;
    end
    scaled = scale_q16(mul_a, mul_g);
    sum    = {{2{smoothed_level[15]}}, smoothed_level} + scaled;

    if (s1.action == tcs_pkg::ACT_DECAY) begin
      applied_next   = scaled[15:0];
      smoothed_next  = smoothed_level;
      waiting_next   = waiting_flag;
      last_sign_next = last_sign;
    end else begin
      smoothed_next = (abs_target < abs_smoothed) ? sum[15:0] : target;
      applied_next  = smoothed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      mid_valid      <= 1'b0;
      applied_level  <= '0;
      smoothed_level <= '0;
      waiting_flag   <= 1'b0;
      last_sign      <= tcs_pkg::SIGN_NONE;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s2_ready) mid_valid <= s1_valid;
      if (step) begin
        applied_level  <= applied_next;
        smoothed_level <= smoothed_next;
        waiting_flag   <= waiting_next;
        last_sign      <= last_sign_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1 <= in_word;
    if (step) begin
      mid_word.applied_torque   <= applied_next;
      mid_word.reversal_blocked <= waiting_next;
    end
  end

endmodule

// File: hdl/tcs_dshot.sv
// ----------------------------------------------------------------------------
// tcs_dshot: bidirectional DShot mapping and result register
// Deadband, saturation at full scale and the 999/4096 ratio.
// ----------------------------------------------------------------------------
module tcs_dshot (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_valid,
  output logic              mid_ready,
  input  tcs_pkg::tcs_mid_t mid_word,
  output logic              res_valid,
  input  logic              res_ready,
  output tcs_pkg::tcs_res_t res_word
);

  logic signed [15:0] a;
  logic [16:0]        mag;
  logic [12:0]        ratio;
  logic [22:0]        prod;
  logic [10:0]        code;
  logic [10:0]        value;

  assign mid_ready = !res_valid || res_ready;

  always_comb begin
    a     = mid_word.applied_torque;
    mag   = a[15] ? 17'(-{a[15], a}) : {1'b0, a};
    ratio = (mag > {4'd0, tcs_pkg::FULL_SCALE}) ? tcs_pkg::FULL_SCALE : mag[12:0];
    prod  = 23'(ratio) * 23'(tcs_pkg::DSHOT_SPAN);
    code  = {1'b0, prod[21:12]};
    if (mag <= tcs_pkg::DSHOT_DEADBAND) value = tcs_pkg::DSHOT_STOP;
    else if (a[15]) value = tcs_pkg::DSHOT_REV_BASE + code;
    else value = tcs_pkg::DSHOT_FWD_BASE + code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (mid_ready) begin
      res_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      res_word.dshot_value      <= value;
      res_word.applied_torque   <= mid_word.applied_torque;
      res_word.reversal_blocked <= mid_word.reversal_blocked;
    end
  end

endmodule
